// File: rtl/irtx_pkg.sv
`default_nettype none
package irtx_pkg;

  // frame buffer depth and derived widths
  localparam int MAX_FRAME_BYTES = 16;
  localparam int LOAD_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IDX_W  = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;

  // configuration register indexes
  localparam logic [2:0] CFG_CARRIER_HIGH   = 3'd0;
  localparam logic [2:0] CFG_CARRIER_PERIOD = 3'd1;
  localparam logic [2:0] CFG_PULSES_UNIT    = 3'd2;
  localparam logic [2:0] CFG_LEADER_UNITS   = 3'd3;
  localparam logic [2:0] CFG_LEADER_SPACE   = 3'd4;
  localparam logic [2:0] CFG_ONE_SPACE      = 3'd5;
  localparam logic [2:0] CFG_ZERO_SPACE     = 3'd6;

  // configuration reset values
  localparam logic [7:0]  RST_CARRIER_HIGH   = 8'd20;
  localparam logic [7:0]  RST_CARRIER_PERIOD = 8'd26;
  localparam logic [7:0]  RST_PULSES_UNIT    = 8'd15;
  localparam logic [3:0]  RST_LEADER_UNITS   = 4'd8;
  localparam logic [15:0] RST_LEADER_SPACE   = 16'd1600;
  localparam logic [15:0] RST_ONE_SPACE      = 16'd1200;
  localparam logic [15:0] RST_ZERO_SPACE     = 16'd400;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } out_item_t;

  // classified beat handed from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       last_byte;
  } cmd_t;

  typedef enum logic [6:0] {
    PH_IDLE        = 7'b0000001,
    PH_LEAD_MARK   = 7'b0000010,
    PH_LEAD_SPACE  = 7'b0000100,
    PH_BIT_MARK    = 7'b0001000,
    PH_BIT_SPACE   = 7'b0010000,
    PH_TRAIL_MARK  = 7'b0100000,
    PH_TRAIL_SPACE = 7'b1000000
  } phase_t;

endpackage
`default_nettype wire

// File: rtl/irtx_front.sv
`default_nettype none
module irtx_front
  import irtx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire in_item_t item,
  output logic          full,
  output logic          cmd_valid,
  output cmd_t          cmd,
  input  wire logic     cmd_take
);

  // two-entry queue of classified beats
  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;
  cmd_t       cls;

  // classify the incoming beat
  always_comb begin
    cls.op        = item.opcode ? OP_LOAD : OP_TICK;
    cls.data_byte = item.data_byte;
    cls.last_byte = item.last_byte;
  end

  assign full      = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// File: rtl/irtx_back.sv
`default_nettype none
module irtx_back
  import irtx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_take,
  input  wire logic        res_full,
  output logic             res_push,
  output out_item_t        res
);

  // configuration registers
  logic [7:0]  ch_r, cp_r, ppu_r;
  logic [3:0]  lu_r;
  logic [15:0] lsp_r, osp_r, zsp_r;

  // frame state
  logic [7:0]        store_r [MAX_FRAME_BYTES];
  phase_t            phase_r, phase_nxt;
  logic [LOAD_W-1:0] loaded_r, loaded_nxt;
  logic [LOAD_W-1:0] send_r, send_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [7:0]        ctc_r, ctc_nxt;
  logic [7:0]        pc_r, pc_nxt;
  logic [3:0]        uc_r, uc_nxt;
  logic [15:0]       space_r, space_nxt;
  logic [7:0]        shift_r, shift_nxt;

  logic              fire;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [7:0]        period, ppu;
  logic [3:0]        lu;
  logic [8:0]        ctc_inc, pc_inc;
  logic [4:0]        uc_inc;
  logic [16:0]       sp_inc;
  logic [LOAD_W-1:0] sp1;
  logic              enter, fin;
  phase_t            enter_ph, fin_ph;
  logic [7:0]        shift_sh;

  function automatic logic [15:0] space_len(phase_t ph, logic lsb, logic [15:0] lead,
                                            logic [15:0] one, logic [15:0] zero);
    logic [15:0] len;
    len = one;
    if (ph == PH_LEAD_SPACE) begin
      len = lead;
    end else if (ph == PH_BIT_SPACE) begin
      len = lsb ? one : zero;
    end
    return len;
  endfunction

  assign fire     = cmd_valid && !res_full;
  assign cmd_take = fire;
  assign res_push = fire;

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r  <= RST_CARRIER_HIGH;
      cp_r  <= RST_CARRIER_PERIOD;
      ppu_r <= RST_PULSES_UNIT;
      lu_r  <= RST_LEADER_UNITS;
      lsp_r <= RST_LEADER_SPACE;
      osp_r <= RST_ONE_SPACE;
      zsp_r <= RST_ZERO_SPACE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CARRIER_HIGH:   ch_r  <= cfg_wdata[7:0];
        CFG_CARRIER_PERIOD: cp_r  <= cfg_wdata[7:0];
        CFG_PULSES_UNIT:    ppu_r <= cfg_wdata[7:0];
        CFG_LEADER_UNITS:   lu_r  <= cfg_wdata[3:0];
        CFG_LEADER_SPACE:   lsp_r <= cfg_wdata;
        CFG_ONE_SPACE:      osp_r <= cfg_wdata;
        CFG_ZERO_SPACE:     zsp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective carrier/unit settings, zero treated as minimum
  always_comb begin
    period = (cp_r > ch_r) ? cp_r : ch_r;
    if (period == 8'd0) begin
      period = 8'd1;
    end
    ppu = (ppu_r == 8'd0) ? 8'd1 : ppu_r;
    lu  = (lu_r == 4'd0) ? 4'd1 : lu_r;
  end

  // one step of the frame sequencer per beat
  always_comb begin
    phase_nxt  = phase_r;
    loaded_nxt = loaded_r;
    send_nxt   = send_r;
    bit_nxt    = bit_r;
    ctc_nxt    = ctc_r;
    pc_nxt     = pc_r;
    uc_nxt     = uc_r;
    space_nxt  = space_r;
    shift_nxt  = shift_r;
    res        = '0;
    wr_en      = 1'b0;
    wr_idx     = loaded_r[IDX_W-1:0];
    enter      = 1'b0;
    enter_ph   = phase_r;
    fin        = 1'b0;
    fin_ph     = phase_r;
    ctc_inc    = {1'b0, ctc_r} + 9'd1;
    pc_inc     = {1'b0, pc_r} + 9'd1;
    uc_inc     = {1'b0, uc_r} + 5'd1;
    sp_inc     = {1'b0, space_r} + 17'd1;
    sp1        = send_r + LOAD_W'(1);
    shift_sh   = {1'b0, shift_r[7:1]};
    rd_idx     = '0;

    if (fire) begin
      if (cmd.op == OP_LOAD) begin
        if (phase_r != PH_IDLE) begin
          res.rejected = 1'b1;
        end else begin
          if (loaded_r >= LOAD_W'(MAX_FRAME_BYTES)) begin
            res.rejected = 1'b1;
          end else begin
            wr_en      = 1'b1;
            loaded_nxt = loaded_r + LOAD_W'(1);
          end
          if (cmd.last_byte && (loaded_nxt != '0)) begin
            phase_nxt = PH_LEAD_MARK;
            send_nxt  = '0;
            bit_nxt   = '0;
            ctc_nxt   = '0;
            pc_nxt    = '0;
            uc_nxt    = '0;
            space_nxt = '0;
            shift_nxt = '0;
          end
        end
        res.busy_res = (phase_nxt != PH_IDLE);
      end else if (phase_r != PH_IDLE) begin
        res.busy_res = 1'b1;
        unique case (phase_r) inside
          PH_LEAD_MARK, PH_BIT_MARK, PH_TRAIL_MARK: begin
            res.ir_level = (ctc_r < ch_r);
            ctc_nxt      = ctc_inc[7:0];
            if (ctc_inc >= {1'b0, period}) begin
              ctc_nxt = '0;
              pc_nxt  = pc_inc[7:0];
              if (pc_inc >= {1'b0, ppu}) begin
                pc_nxt = '0;
                if (phase_r == PH_LEAD_MARK) begin
                  uc_nxt = uc_inc[3:0];
                  if (uc_inc >= {1'b0, lu}) begin
                    uc_nxt   = '0;
                    enter    = 1'b1;
                    enter_ph = PH_LEAD_SPACE;
                  end
                end else if (phase_r == PH_BIT_MARK) begin
                  enter    = 1'b1;
                  enter_ph = PH_BIT_SPACE;
                end else begin
                  enter    = 1'b1;
                  enter_ph = PH_TRAIL_SPACE;
                end
              end
            end
          end
          PH_LEAD_SPACE, PH_BIT_SPACE, PH_TRAIL_SPACE: begin
            space_nxt = sp_inc[15:0];
            if (sp_inc >= {1'b0, space_len(phase_r, shift_r[0], lsp_r, osp_r, zsp_r)}) begin
              fin    = 1'b1;
              fin_ph = phase_r;
            end
          end
          default: ;
        endcase

        // entering a space; an empty space finishes at once
        if (enter) begin
          phase_nxt = enter_ph;
          space_nxt = '0;
          if (space_len(enter_ph, shift_r[0], lsp_r, osp_r, zsp_r) == 16'd0) begin
            fin    = 1'b1;
            fin_ph = enter_ph;
          end
        end

        // end of a space
        if (fin) begin
          space_nxt = '0;
          rd_idx    = (fin_ph == PH_LEAD_SPACE) ? '0 : sp1[IDX_W-1:0];
          if (fin_ph == PH_LEAD_SPACE) begin
            send_nxt  = '0;
            shift_nxt = store_r[rd_idx];
            bit_nxt   = '0;
            phase_nxt = PH_BIT_MARK;
          end else if (fin_ph == PH_BIT_SPACE) begin
            if (bit_r == 3'd7) begin
              send_nxt = sp1;
              if (sp1 >= loaded_r) begin
                phase_nxt = PH_TRAIL_MARK;
                shift_nxt = shift_sh;
              end else begin
                shift_nxt = store_r[rd_idx];
                bit_nxt   = '0;
                phase_nxt = PH_BIT_MARK;
              end
            end else begin
              bit_nxt   = bit_r + 3'd1;
              shift_nxt = shift_sh;
              phase_nxt = PH_BIT_MARK;
            end
          end else begin
            phase_nxt      = PH_IDLE;
            loaded_nxt     = '0;
            send_nxt       = '0;
            bit_nxt        = '0;
            shift_nxt      = '0;
            res.frame_done = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      loaded_r <= '0;
      send_r   <= '0;
      bit_r    <= '0;
      ctc_r    <= '0;
      pc_r     <= '0;
      uc_r     <= '0;
      space_r  <= '0;
      shift_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      loaded_r <= loaded_nxt;
      send_r   <= send_nxt;
      bit_r    <= bit_nxt;
      ctc_r    <= ctc_nxt;
      pc_r     <= pc_nxt;
      uc_r     <= uc_nxt;
      space_r  <= space_nxt;
      shift_r  <= shift_nxt;
    end
  end

  // frame byte buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= cmd.data_byte;
    end
  end

endmodule
`default_nettype wire

// File: rtl/irtx_outq.sv
`default_nettype none
module irtx_outq
  import irtx_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t item,
  output logic           full,
  output logic           empty,
  output out_item_t      head,
  input  wire logic      pop
);

  // two-entry result queue
  out_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ir_remote_frame_transmitter.sv
`default_nettype none
// A pushed beat is stored in the front queue, executed by the back end and its result
// stored in the result queue, whose head drives out_data; a full result queue stalls.
// Throughput: one beat per cycle while the result queue has room; the frame sequencer
// does one tick or one byte load per beat, with two-entry queues on both sides.
// Reset: synchronous, active low; both queues empty, sequencer idle, buffer count
// zero, config registers to their defaults. Buffer contents are not cleared.
module ir_remote_frame_transmitter
  import irtx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire in_item_t    in_data,
  output logic             in_full,
  output logic             out_empty,
  output out_item_t        out_data,
  input  wire logic        out_pop,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic      cmd_valid, cmd_take;
  cmd_t      cmd;
  logic      res_push, res_full;
  out_item_t res;

  assign cfg_ready = 1'b1;

  irtx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .item      (in_data),
    .full      (in_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  irtx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  irtx_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .item  (res),
    .full  (res_full),
    .empty (out_empty),
    .head  (out_data),
    .pop   (out_pop)
  );

endmodule
`default_nettype wire
